// ===== rtl/avc_pkg.sv =====
// Shared types, register indexes and saturation helper for the axis value conditioner.
// No dependencies; imported by the core, its checker and the testbench files.
package avc_pkg;

  localparam int AVC_FRACTION_BITS = 16;
  localparam int AVC_VALUE_W       = 32;
  localparam int AVC_SAT_W         = 66;
  localparam int AVC_CFG_IDX_W     = 3;
  localparam int AVC_CFG_DATA_W    = 32;

  // Register indexes on the configuration port
  localparam logic [AVC_CFG_IDX_W-1:0] CFG_MODE_FLAGS     = 3'd0;
  localparam logic [AVC_CFG_IDX_W-1:0] CFG_FIXED_VALUE    = 3'd1;
  localparam logic [AVC_CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 3'd2;
  localparam logic [AVC_CFG_IDX_W-1:0] CFG_DEAD_ZONE_GAIN = 3'd3;
  localparam logic [AVC_CFG_IDX_W-1:0] CFG_SCALE_FACTOR   = 3'd4;

  // Bit positions in mode_flags
  localparam int MODE_FIXED  = 0;
  localparam int MODE_CENTER = 1;
  localparam int MODE_DZONE  = 2;
  localparam int MODE_FLIP   = 3;
  localparam int MODE_SQUARE = 4;
  localparam int MODE_CUBE   = 5;
  localparam int MODE_SCALE  = 6;
  localparam int MODE_W      = 7;

  typedef struct packed {
    logic signed [AVC_VALUE_W-1:0] sample_value;
    logic                          source_is_mouse;
  } avc_in_t;

  typedef struct packed {
    logic signed [AVC_VALUE_W-1:0] conditioned_value;
    logic                          saturated;
  } avc_out_t;

  typedef struct packed {
    logic                          clip;
    logic signed [AVC_VALUE_W-1:0] value;
  } avc_sat_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic avc_sat_t sat_q(input logic signed [AVC_SAT_W-1:0] x);
    avc_sat_t r;
    if (x > AVC_SAT_W'(32'sh7FFF_FFFF)) begin
      r.clip  = 1'b1;
      r.value = 32'sh7FFF_FFFF;
    end else if (x < AVC_SAT_W'(32'sh8000_0000)) begin
      r.clip  = 1'b1;
      r.value = 32'sh8000_0000;
    end else begin
      r.clip  = 1'b0;
      r.value = x[AVC_VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/axis_value_conditioner_core.sv =====
// Axis value conditioner: twelve-stage pipeline of fixed-value override, centring,
// dead zone, flip, square, cube and gain on signed fixed-point items. Depends on avc_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | in        | in_valid / in_stall  | avc_in_t  (sample, mouse flag)
//  out_    | out       | out_valid / out_stall| avc_out_t (value, saturated)
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (5 registers)
//
// One item may enter every cycle while no result is held at the output. The stages
// are the entry and dead-zone offset stages, then five multiplier stages, each
// followed by a stage that shifts the registered product and clamps it or flags overflow.
// rst_n (synchronous) clears every stage valid bit and loads the register defaults.
// A held result at the output freezes the whole pipeline; in_stall follows
// out_valid & out_stall, so nothing is dropped or repeated.
// cfg_ready is always high; writes are expected only while the pipeline is empty.
module axis_value_conditioner_core
  import avc_pkg::*;
#(
  parameter int FRACTION_BITS = AVC_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  avc_in_t                     in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output avc_out_t                    out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [AVC_CFG_IDX_W-1:0]    cfg_index,
  input  logic [AVC_CFG_DATA_W-1:0]   cfg_data
);

  localparam int VW = AVC_VALUE_W;
  localparam logic signed [VW+1:0] ONE_X = (VW+2)'(1) <<< FRACTION_BITS;

  // Per-item control that travels down the pipe. mode is cleared for
  // fixed-value items so every later step passes them through untouched.
  typedef struct packed {
    logic                   valid;
    logic [MODE_W-1:0]      mode;
    logic                   mouse;
    logic                   clip;
    logic signed [VW-1:0]   v;
  } ctl_t;

  // ---------------------------------------------------------------- config
  logic [MODE_W-1:0]    mode_flags_r;
  logic signed [VW-1:0] fixed_value_r;
  logic [15:0]          dead_zone_r;
  logic [30:0]          dead_zone_gain_r;
  logic signed [VW-1:0] scale_factor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_flags_r     <= '0;
      fixed_value_r    <= '0;
      dead_zone_r      <= '0;
      dead_zone_gain_r <= 31'(1) << FRACTION_BITS;
      scale_factor_r   <= VW'(1) <<< FRACTION_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE_FLAGS:     mode_flags_r     <= cfg_data[MODE_W-1:0];
        CFG_FIXED_VALUE:    fixed_value_r    <= $signed(cfg_data);
        CFG_DEAD_ZONE:      dead_zone_r      <= cfg_data[15:0];
        CFG_DEAD_ZONE_GAIN: dead_zone_gain_r <= cfg_data[30:0];
        CFG_SCALE_FACTOR:   scale_factor_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Global advance: the whole pipe moves unless a result is held at the output.
  logic adv;
  ctl_t out_r;

  assign adv      = !out_r.valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------- stage 1: entry, centre
  ctl_t s1_r, s1_nxt;

  always_comb begin
    logic signed [VW+1:0] c;
    avc_sat_t sr;
    c  = '0;
    sr = '0;
    s1_nxt.valid = in_valid;
    s1_nxt.mode  = mode_flags_r;
    s1_nxt.mouse = in_data.source_is_mouse;
    s1_nxt.clip  = 1'b0;
    s1_nxt.v     = in_data.sample_value;
    if (mode_flags_r[MODE_FIXED]) begin
      s1_nxt.mode = '0;
      s1_nxt.v    = fixed_value_r;
    end else if (mode_flags_r[MODE_CENTER] && !in_data.source_is_mouse) begin
      c  = ONE_X - ((VW+2)'(in_data.sample_value) <<< 1);
      sr = sat_q(AVC_SAT_W'(c));
      s1_nxt.v    = sr.value;
      s1_nxt.clip = sr.clip;
    end
  end

  // ---------------------------------------------------------------- stage 2: dead-zone offset
  ctl_t s2_r, s2_nxt;
  logic signed [VW:0] s2_d_r, s2_d_nxt;
  logic               s2_zero_r, s2_zero_nxt;

  always_comb begin
    logic signed [VW:0] v33;
    logic signed [VW:0] dz33;
    v33  = (VW+1)'(s1_r.v);
    dz33 = $signed({(VW+1-16)'(0), dead_zone_r});
    s2_nxt = s1_r;
    if (s1_r.v > 0) begin
      s2_zero_nxt = v33 < dz33;
      s2_d_nxt    = v33 - dz33;
    end else begin
      s2_zero_nxt = v33 > -dz33;
      s2_d_nxt    = v33 + dz33;
    end
  end

  // ---------------------------------------------------------------- stage 3: dead-zone gain product
  ctl_t s3_r;
  logic signed [2*VW:0] s3_p_r, s3_p_nxt;
  logic                 s3_zero_r;

  assign s3_p_nxt = s2_d_r * $signed({1'b0, dead_zone_gain_r});

  // ---------------------------------------------------------------- stage 4: dead-zone resolve, flip
  ctl_t s4_r, s4_nxt;

  always_comb begin
    avc_sat_t sr;
    logic signed [VW+1:0] f;
    sr = '0;
    f  = '0;
    s4_nxt = s3_r;
    if (s3_r.mode[MODE_DZONE]) begin
      if (s3_zero_r) begin
        s4_nxt.v = '0;
      end else begin
        sr = sat_q(AVC_SAT_W'(s3_p_r >>> FRACTION_BITS));
        s4_nxt.v    = sr.value;
        s4_nxt.clip = s4_nxt.clip | sr.clip;
      end
    end
    if (s3_r.mode[MODE_FLIP]) begin
      // uncentred stick input flips about one, everything else about zero
      if (!s3_r.mode[MODE_CENTER] && !s3_r.mouse) begin
        f = ONE_X - (VW+2)'(s4_nxt.v);
      end else begin
        f = -(VW+2)'(s4_nxt.v);
      end
      sr = sat_q(AVC_SAT_W'(f));
      s4_nxt.v    = sr.value;
      s4_nxt.clip = s4_nxt.clip | sr.clip;
    end
  end

  // ---------------------------------------------------------------- stage 5: square product
  ctl_t s5_r;
  logic signed [2*VW-1:0] s5_p_r, s5_p_nxt;

  assign s5_p_nxt = s4_r.v * s4_r.v;

  // ---------------------------------------------------------------- stage 6: square resolve
  ctl_t s6_r, s6_nxt;

  always_comb begin
    avc_sat_t sr;
    sr = sat_q(AVC_SAT_W'(s5_p_r >>> FRACTION_BITS));
    s6_nxt = s5_r;
    if (s5_r.mode[MODE_SQUARE]) begin
      // magnitude is non-negative, so negating it cannot clip
      s6_nxt.v    = (s5_r.v < 0) ? -sr.value : sr.value;
      s6_nxt.clip = s5_r.clip | sr.clip;
    end
  end

  // ---------------------------------------------------------------- stage 7: cube, square product
  ctl_t s7_r;
  logic signed [2*VW-1:0] s7_p_r, s7_p_nxt;

  assign s7_p_nxt = s6_r.v * s6_r.v;

  // ---------------------------------------------------------------- stage 8: cube, square shift
  ctl_t s8_r;
  logic signed [VW-1:0]   s8_t_r, s8_t_nxt;
  logic                   s8_ovf_r, s8_ovf_nxt;
  logic signed [2*VW-1:0] s8_sh;

  assign s8_sh      = s7_p_r >>> FRACTION_BITS;
  assign s8_ovf_nxt = |s8_sh[2*VW-1:VW-1];
  assign s8_t_nxt   = s8_sh[VW-1:0];

  // ---------------------------------------------------------------- stage 9: cube, final product
  ctl_t s9_r;
  logic signed [2*VW-1:0] s9_p_r, s9_p_nxt;
  logic                   s9_ovf_r;

  assign s9_p_nxt = s8_t_r * s8_r.v;

  // ---------------------------------------------------------------- stage 10: cube resolve
  ctl_t s10_r, s10_nxt;

  always_comb begin
    avc_sat_t sr;
    sr = sat_q(AVC_SAT_W'(s9_p_r >>> FRACTION_BITS));
    s10_nxt = s9_r;
    if (s9_r.mode[MODE_CUBE]) begin
      if (s9_ovf_r) begin
        // square already out of range: clip with the sign of v
        s10_nxt.clip = 1'b1;
        s10_nxt.v    = (s9_r.v < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        s10_nxt.v    = sr.value;
        s10_nxt.clip = s9_r.clip | sr.clip;
      end
    end
  end

  // ---------------------------------------------------------------- stage 11: scale product
  ctl_t s11_r;
  logic signed [2*VW-1:0] s11_p_r, s11_p_nxt;

  assign s11_p_nxt = s10_r.v * scale_factor_r;

  // ---------------------------------------------------------------- stage 12: scale resolve, output
  ctl_t out_nxt;

  always_comb begin
    avc_sat_t sr;
    sr = sat_q(AVC_SAT_W'(s11_p_r >>> FRACTION_BITS));
    out_nxt = s11_r;
    if (s11_r.mode[MODE_SCALE]) begin
      out_nxt.v    = sr.value;
      out_nxt.clip = s11_r.clip | sr.clip;
    end
  end

  // ---------------------------------------------------------------- pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      s3_r.valid  <= 1'b0;
      s4_r.valid  <= 1'b0;
      s5_r.valid  <= 1'b0;
      s6_r.valid  <= 1'b0;
      s7_r.valid  <= 1'b0;
      s8_r.valid  <= 1'b0;
      s9_r.valid  <= 1'b0;
      s10_r.valid <= 1'b0;
      s11_r.valid <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s2_r;
      s4_r  <= s4_nxt;
      s5_r  <= s4_r;
      s6_r  <= s6_nxt;
      s7_r  <= s6_r;
      s8_r  <= s7_r;
      s9_r  <= s8_r;
      s10_r <= s10_nxt;
      s11_r <= s10_r;
      out_r <= out_nxt;
    end
  end

  // payload-only side registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d_r    <= s2_d_nxt;
      s2_zero_r <= s2_zero_nxt;
      s3_p_r    <= s3_p_nxt;
      s3_zero_r <= s2_zero_r;
      s5_p_r    <= s5_p_nxt;
      s7_p_r    <= s7_p_nxt;
      s8_t_r    <= s8_t_nxt;
      s8_ovf_r  <= s8_ovf_nxt;
      s9_p_r    <= s9_p_nxt;
      s9_ovf_r  <= s8_ovf_r;
      s11_p_r   <= s11_p_nxt;
    end
  end

  assign out_valid                  = out_r.valid;
  assign out_data.conditioned_value = out_r.v;
  assign out_data.saturated         = out_r.clip;

endmodule

// ===== rtl/avc_checker.sv =====
// Port-level checks for axis_value_conditioner_core, bound into every core instance.
// Depends on avc_pkg.
module avc_checker
  import avc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input avc_in_t                   in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input avc_out_t                  out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [AVC_CFG_IDX_W-1:0]  cfg_index,
  input logic [AVC_CFG_DATA_W-1:0] cfg_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // input is held off exactly when the output register is occupied and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output back-pressure");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind axis_value_conditioner_core avc_checker u_avc_checker (.*);

// ===== tb/sv/avc_conditioner_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the axis value conditioner: predicts each result from
// accepted samples and a private register copy. Needs avc_pkg.
module avc_conditioner_checker
  import avc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  avc_in_t                   in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  avc_out_t                  out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [AVC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [AVC_CFG_DATA_W-1:0] cfg_data,
  output int                        mismatch_count,
  output int                        results_pending
);

  localparam longint UNITY = longint'(1) << AVC_FRACTION_BITS;
  localparam longint Q_MAX = 64'sh7FFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;

  logic [MODE_W-1:0]             mode_q;
  logic signed [AVC_VALUE_W-1:0] fixed_q;
  logic [15:0]                   dz_q;
  logic [30:0]                   gain_q;
  logic signed [AVC_VALUE_W-1:0] scale_q;

  avc_out_t conditioned_fifo[$];
  bit       clipped;

  function automatic longint clamp_q(input longint x);
    if (x > Q_MAX) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (x < Q_MIN) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return x;
  endfunction

  // product, floored to the fraction grid, then clamped
  function automatic longint fix_mul(input longint a, input longint b);
    return clamp_q((a * b) >>> AVC_FRACTION_BITS);
  endfunction

  function automatic avc_out_t condition_sample(input avc_in_t s);
    longint   v;
    longint   t;
    longint   dz;
    longint   g;
    bit       mouse;
    bit       neg;
    avc_out_t r;
    clipped = 1'b0;
    mouse   = s.source_is_mouse;
    if (mode_q[MODE_FIXED]) begin
      r.conditioned_value = fixed_q;
      r.saturated         = 1'b0;
      return r;
    end
    v  = longint'($signed(s.sample_value));
    dz = longint'(dz_q);
    g  = longint'(gain_q);
    if (mode_q[MODE_CENTER] && !mouse)
      v = clamp_q(UNITY - 2 * v);
    if (mode_q[MODE_DZONE]) begin
      if (v > 0) begin
        if (v < dz)
          v = 0;
        else
          v = fix_mul(v - dz, g);
      end else begin
        if (v > -dz)
          v = 0;
        else
          v = fix_mul(v + dz, g);
      end
    end
    if (mode_q[MODE_FLIP]) begin
      if (!mode_q[MODE_CENTER] && !mouse)
        v = clamp_q(UNITY - v);
      else
        v = clamp_q(-v);
    end
    if (mode_q[MODE_SQUARE]) begin
      neg = (v < 0);
      v   = fix_mul(v, v);
      if (neg)
        v = clamp_q(-v);
    end
    if (mode_q[MODE_CUBE]) begin
      t = (v * v) >>> AVC_FRACTION_BITS;
      if (t > Q_MAX) begin
        clipped = 1'b1;
        v       = (v < 0) ? Q_MIN : Q_MAX;
      end else begin
        v = fix_mul(t, v);
      end
    end
    if (mode_q[MODE_SCALE])
      v = fix_mul(v, longint'(scale_q));
    r.conditioned_value = 32'(v);
    r.saturated         = clipped;
    return r;
  endfunction

  always @(posedge clk) begin : track
    avc_out_t want;
    if (!rst_n) begin
      mode_q  = '0;
      fixed_q = '0;
      dz_q    = '0;
      gain_q  = 31'(UNITY);
      scale_q = 32'(UNITY);
      conditioned_fifo.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE_FLAGS:     mode_q  = cfg_data[MODE_W-1:0];
          CFG_FIXED_VALUE:    fixed_q = cfg_data;
          CFG_DEAD_ZONE:      dz_q    = cfg_data[15:0];
          CFG_DEAD_ZONE_GAIN: gain_q  = cfg_data[30:0];
          CFG_SCALE_FACTOR:   scale_q = cfg_data;
          default:            ;
        endcase
      end
      if (in_valid && !in_stall)
        conditioned_fifo = {conditioned_fifo, condition_sample(in_data)};
      if (out_valid && !out_stall) begin
        if (conditioned_fifo.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item, expected none, got value %0d saturated %0b",
                   $time, $signed(out_data.conditioned_value), out_data.saturated);
        end else begin
          want = conditioned_fifo.pop_front();
          if (out_data.conditioned_value !== want.conditioned_value) begin
            mismatch_count++;
            $display("%0t: conditioned_value expected %0d got %0d", $time,
                     $signed(want.conditioned_value), $signed(out_data.conditioned_value));
          end
          if (out_data.saturated !== want.saturated) begin
            mismatch_count++;
            $display("%0t: saturated expected %0b got %0b", $time,
                     want.saturated, out_data.saturated);
          end
        end
      end
    end
    results_pending = conditioned_fifo.size();
  end

endmodule

// ===== tb/sv/tb_axis_value_conditioner_core.sv =====
`timescale 1ns / 100ps
// Top-level testbench for axis_value_conditioner_core: clock, reset, register
// programming and sample stimulus. Needs avc_pkg and avc_conditioner_checker.
module tb_axis_value_conditioner_core;
  import avc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 152;
  localparam int IDLE_PERCENT   = 10;
  localparam int HOLD_CYCLES    = 120;  // long receiver hold-off, well past pipe depth
  localparam int TAIL_CYCLES    = 24;   // idle run-out after the last drain, before the final report
  localparam int WATCHDOG_LIMIT = 4000;

  localparam int Q_ONE = 1 << AVC_FRACTION_BITS;
  localparam int Q_MAX = 32'sh7FFF_FFFF;
  localparam int Q_MIN = 32'sh8000_0000;

  localparam logic [MODE_W-1:0] M_FIXED  = MODE_W'(1) << MODE_FIXED;
  localparam logic [MODE_W-1:0] M_CENTER = MODE_W'(1) << MODE_CENTER;
  localparam logic [MODE_W-1:0] M_DZONE  = MODE_W'(1) << MODE_DZONE;
  localparam logic [MODE_W-1:0] M_FLIP   = MODE_W'(1) << MODE_FLIP;
  localparam logic [MODE_W-1:0] M_SQUARE = MODE_W'(1) << MODE_SQUARE;
  localparam logic [MODE_W-1:0] M_CUBE   = MODE_W'(1) << MODE_CUBE;
  localparam logic [MODE_W-1:0] M_SCALE  = MODE_W'(1) << MODE_SCALE;
  localparam logic [MODE_W-1:0] M_ALL_STEPS =
    M_CENTER | M_DZONE | M_FLIP | M_SQUARE | M_CUBE | M_SCALE;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  avc_in_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  avc_out_t                  out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [AVC_CFG_IDX_W-1:0]  cfg_index;
  logic [AVC_CFG_DATA_W-1:0] cfg_data;

  int          mismatch_count;
  int          results_pending;
  bit          idle_on  = 1'b1;  // random idling on both sides
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
  logic [15:0] cur_dz;           // dead zone in force, used to aim samples at its edges

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  axis_value_conditioner_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  avc_conditioner_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or one long counted hold-off on request. During
  // the hold-off the twelve-stage pipe freezes once a result is held, and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        out_stall <= 1'b0;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run once nothing has moved on any channel for too long.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_axis_value_conditioner_core: done, errors");
    $finish;
  end

  function automatic avc_in_t axis_item(input logic signed [31:0] value, input logic mouse);
    avc_in_t s;
    s.sample_value    = value;
    s.source_is_mouse = mouse;
    return s;
  endfunction

  // Mostly realistic axis range, plus full-range noise, dead zone edges
  // (directly and as seen after centring) and the extremes.
  function automatic avc_in_t random_sample(input logic [15:0] dz);
    avc_in_t s;
    int      pick;
    int      base;
    pick = $urandom_range(0, 99);
    s.source_is_mouse = 1'($urandom_range(0, 1));
    if (pick < 45) begin
      s.sample_value = int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
    end else if (pick < 70) begin
      s.sample_value = $urandom();
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0:       base = dz;
        1:       base = -int'(dz);
        2:       base = (Q_ONE - int'(dz)) / 2;
        default: base = (Q_ONE + int'(dz)) / 2;
      endcase
      s.sample_value = base + int'($urandom_range(0, 6)) - 3;
    end else begin
      case ($urandom_range(0, 5))
        0:       s.sample_value = Q_MAX;
        1:       s.sample_value = Q_MIN;
        2:       s.sample_value = 0;
        3:       s.sample_value = Q_ONE;
        4:       s.sample_value = -Q_ONE;
        default: s.sample_value = Q_ONE / 2;
      endcase
    end
    return s;
  endfunction

  // Offer one item with random idle cycles ahead of it; returns on the edge that
  // takes it, leaving valid high so back-to-back items need no extra edge.
  task automatic offer_sample(input avc_in_t item);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [AVC_CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all five registers, with junk in the bits above each register's width,
  // and optionally pokes the unmapped indexes, which must change nothing.
  task automatic program_regs(input logic [MODE_W-1:0] mode,
                              input logic signed [31:0] fixed_v,
                              input logic [15:0] dz,
                              input logic [30:0] gain,
                              input logic signed [31:0] scale,
                              input bit with_unmapped);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_MODE_FLAGS, {junk[31:MODE_W], mode});
    write_reg(CFG_FIXED_VALUE, fixed_v);
    write_reg(CFG_DEAD_ZONE, {junk[31:16], dz});
    write_reg(CFG_DEAD_ZONE_GAIN, {junk[31], gain});
    write_reg(CFG_SCALE_FACTOR, scale);
    if (with_unmapped) begin
      for (int i = int'(CFG_SCALE_FACTOR) + 1; i < (1 << AVC_CFG_IDX_W); i++)
        write_reg(AVC_CFG_IDX_W'(i), $urandom());
    end
    cfg_valid <= 1'b0;
    cur_dz = dz;
  endtask

  // Stop offering and wait for every outstanding item; registers may be
  // written afterwards. Polled on the falling edge, driving resumes on the rising.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                   p;
    int                   k;
    logic [MODE_W-1:0]    mode;
    logic [15:0]          dz;
    logic [30:0]          gain;
    logic signed [31:0]   fixed_v;
    logic signed [31:0]   scale;
    longint               gain_wide;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_dz    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fixed-value mode wins over every other step, flag stays clear
    program_regs(M_FIXED | M_ALL_STEPS, Q_MIN, 16'hFFFF, 31'h7FFF_FFFF, Q_MAX, 1'b0);
    offer_sample(axis_item(Q_MAX, 1'b0));
    offer_sample(axis_item(0, 1'b1));
    drain_results();

    // Every step at once with the widest dead zone and gain, most negative scale
    program_regs(M_ALL_STEPS, Q_MAX, 16'hFFFF, 31'h7FFF_FFFF, Q_MIN, 1'b0);
    offer_sample(axis_item(Q_MIN, 1'b0));
    offer_sample(axis_item(Q_MAX, 1'b1));
    offer_sample(axis_item(0, 1'b0));
    offer_sample(axis_item(Q_ONE / 2, 1'b0));
    offer_sample(axis_item(-1, 1'b1));
    drain_results();

    // Dead zone with rescale, then flip: 1-v for joystick, -v for mouse
    program_regs(M_DZONE | M_FLIP, 0, 16'h4000, 31'd87381, Q_ONE, 1'b0);
    offer_sample(axis_item(Q_ONE / 8, 1'b0));
    offer_sample(axis_item(-Q_ONE / 8, 1'b1));
    offer_sample(axis_item(Q_ONE, 1'b0));
    offer_sample(axis_item(-Q_ONE, 1'b1));
    offer_sample(axis_item(-3, 1'b1));
    drain_results();

    // Square then cube: cube overflow from an already huge square, floor rounding
    program_regs(M_SQUARE | M_CUBE, 0, 16'h0000, 31'(Q_ONE), Q_ONE, 1'b0);
    offer_sample(axis_item(Q_MAX, 1'b0));
    offer_sample(axis_item(Q_MIN, 1'b1));
    offer_sample(axis_item(-Q_ONE - 1, 1'b0));
    offer_sample(axis_item(3 * Q_ONE, 1'b1));
    drain_results();

    // Gain below one and a tiny negative scale: products floor toward minus infinity
    program_regs(M_DZONE | M_SCALE, 0, 16'h0000, 31'(Q_ONE / 2), -1, 1'b0);
    offer_sample(axis_item(-5, 1'b0));
    offer_sample(axis_item(7, 1'b1));
    offer_sample(axis_item(Q_MIN, 1'b0));
    drain_results();

    // Centring clips at the extremes and is skipped for mouse; writes to
    // unmapped indexes follow and must be ignored
    program_regs(M_CENTER | M_SCALE, 0, 16'h0000, 31'(Q_ONE), 2 * Q_ONE, 1'b1);
    offer_sample(axis_item(Q_MIN, 1'b0));
    offer_sample(axis_item(Q_MAX, 1'b0));
    offer_sample(axis_item(Q_ONE, 1'b1));
    drain_results();

    // Random phases, each with its own register setting
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        // top of every register range
        mode    = M_ALL_STEPS;
        fixed_v = Q_MAX;
        dz      = 16'hFFFF;
        gain    = 31'h7FFF_FFFF;
        scale   = Q_MAX;
      end else if (p == 1) begin
        // bottom of every range; dead zone and scale on so they matter
        mode    = M_DZONE | M_SCALE;
        fixed_v = Q_MIN;
        dz      = 16'h0000;
        gain    = 31'h0000_0000;
        scale   = Q_MIN;
      end else begin
        mode = MODE_W'($urandom());
        if ($urandom_range(0, 7) != 0)
          mode = mode & ~M_FIXED;
        if (p == 2)
          mode = '0;  // pass-through
        fixed_v = $urandom();
        case ($urandom_range(0, 5))
          0:       dz = 16'h0000;
          1:       dz = 16'hFFFF;
          default: dz = 16'($urandom_range(0, 16'h7FFF));
        endcase
        case ($urandom_range(0, 4))
          0:       gain = 31'($urandom());
          1:       gain = 31'h7FFF_FFFF;
          default: begin
            // what software would program: one over one minus the dead zone
            gain_wide = (longint'(1) << 32) / (longint'(Q_ONE) - longint'(dz));
            gain      = (gain_wide > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(gain_wide);
          end
        endcase
        case ($urandom_range(0, 4))
          0:       scale = $urandom();
          1:       scale = Q_MIN;
          2:       scale = Q_MAX;
          default: scale = int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
        endcase
      end
      program_regs(mode, fixed_v, dz, gain, scale, 1'b0);

      if (p == 3)
        hold_req <= 1'b1;  // receiver backs up while samples keep coming
      if (p == 8)
        idle_on <= 1'b0;   // two phases at full rate on both sides
      if (p == 10)
        idle_on <= 1'b1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 6 && k == PHASE_ITEMS / 2)
          drain_results();  // sender pauses until the pipe is empty
        offer_sample(random_sample(cur_dz));
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_axis_value_conditioner_core: done, clean");
    else
      $display("tb_axis_value_conditioner_core: done, errors");
    $finish;
  end

endmodule
